/* sv/ksa_pkg.sv */
// Shared definitions for the set-1 scancode to ASCII converter.
// Holds scancode constants, action codes and the constant key map ROM.
// No dependencies.
package ksa_pkg;

  localparam int MAP_ENTRIES_DEF = 86;

  localparam logic [7:0] SC_RELEASE      = 8'h80;
  localparam logic [7:0] SC_PREFIX_EXT   = 8'hE0;
  localparam logic [7:0] SC_PREFIX_PAUSE = 8'hE1;
  localparam logic [7:0] SC_CAPS         = 8'h3A;
  localparam logic [7:0] SC_RSHIFT       = 8'h36;
  localparam logic [7:0] SC_LSHIFT       = 8'h2A;
  localparam logic [7:0] SC_CTRL         = 8'h1D;
  localparam logic [7:0] SC_CTRL_UP      = 8'h9D;
  localparam logic [7:0] SC_RSHIFT_UP    = 8'hB6;
  localparam logic [7:0] SC_LSHIFT_UP    = 8'hAA;
  localparam logic [7:0] SC_KEY_L        = 8'h26;
  localparam logic [7:0] SC_KEY_TAB      = 8'h0F;

  localparam logic [1:0] PAUSE_SKIP_LOAD = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_SWITCH = 2'd2
  } ctrl_action_t;

  // Unshifted, lower-case layout.
  function automatic logic [7:0] base_map(input logic [6:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (idx)
      7'h02: ch = "1";
      7'h03: ch = "2";
      7'h04: ch = "3";
      7'h05: ch = "4";
      7'h06: ch = "5";
      7'h07: ch = "6";
      7'h08: ch = "7";
      7'h09: ch = "8";
      7'h0A: ch = "9";
      7'h0B: ch = "0";
      7'h0C: ch = "-";
      7'h0D: ch = "=";
      7'h0E: ch = 8'h08;
      7'h0F: ch = 8'h09;
      7'h10: ch = "q";
      7'h11: ch = "w";
      7'h12: ch = "e";
      7'h13: ch = "r";
      7'h14: ch = "t";
      7'h15: ch = "y";
      7'h16: ch = "u";
      7'h17: ch = "i";
      7'h18: ch = "o";
      7'h19: ch = "p";
      7'h1A: ch = "[";
      7'h1B: ch = "]";
      7'h1C: ch = 8'h0A;
      7'h1E: ch = "a";
      7'h1F: ch = "s";
      7'h20: ch = "d";
      7'h21: ch = "f";
      7'h22: ch = "g";
      7'h23: ch = "h";
      7'h24: ch = "j";
      7'h25: ch = "k";
      7'h26: ch = "l";
      7'h27: ch = ";";
      7'h28: ch = 8'h27;
      7'h29: ch = 8'h60;
      7'h2B: ch = 8'h5C;
      7'h2C: ch = "z";
      7'h2D: ch = "x";
      7'h2E: ch = "c";
      7'h2F: ch = "v";
      7'h30: ch = "b";
      7'h31: ch = "n";
      7'h32: ch = "m";
      7'h33: ch = ",";
      7'h34: ch = ".";
      7'h35: ch = "/";
      7'h39: ch = " ";
      7'h4A: ch = "-";
      7'h4E: ch = "+";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Keys that change under shift (symbols, with tab and enter cleared to zero); everything else falls back to base.
  function automatic logic [7:0] shift_map(input logic [6:0] idx);
    logic [7:0] ch;
    ch = base_map(idx);
    case (idx)
      7'h02: ch = "!";
      7'h03: ch = "@";
      7'h04: ch = "#";
      7'h05: ch = "$";
      7'h06: ch = "%";
      7'h07: ch = "^";
      7'h08: ch = "&";
      7'h09: ch = "*";
      7'h0A: ch = "(";
      7'h0B: ch = ")";
      7'h0C: ch = "_";
      7'h0D: ch = "+";
      7'h0F: ch = 8'h00;
      7'h1A: ch = "{";
      7'h1B: ch = "}";
      7'h1C: ch = 8'h00;
      7'h27: ch = ":";
      7'h28: ch = 8'h22;
      7'h29: ch = "~";
      7'h2B: ch = "|";
      7'h33: ch = "<";
      7'h34: ch = ">";
      7'h35: ch = "?";
      default: ch = ch;
    endcase
    return ch;
  endfunction

  function automatic logic is_letter(input logic [6:0] idx);
    return (idx >= 7'h10 && idx <= 7'h19) || (idx >= 7'h1E && idx <= 7'h26) ||
           (idx >= 7'h2C && idx <= 7'h32);
  endfunction

  // Map select: bit 1 is shift, bit 0 is caps. Letters are upper case when
  // exactly one of the two is active.
  function automatic logic [7:0] key_map(input logic [1:0] which, input logic [6:0] idx);
    logic [7:0] ch;
    if (is_letter(idx)) begin
      ch = base_map(idx);
      if (which[1] ^ which[0]) begin
        ch = ch - 8'h20;
      end
    end else if (which[1]) begin
      ch = shift_map(idx);
    end else begin
      ch = base_map(idx);
    end
    return ch;
  endfunction

endpackage

/* sv/ksa_if.sv */
// Valid/ready channel interfaces for the scancode converter.
// Depends on nothing; one interface for scancode beats, one for result beats.
interface ksa_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scancode;

  modport source (output valid, output scancode, input ready);
  modport sink (input valid, input scancode, output ready);
endinterface

interface ksa_char_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_code;
  logic       extended_key;
  logic [1:0] ctrl_action;

  modport source (output valid, output char_valid, output char_code,
                  output extended_key, output ctrl_action, input ready);
  modport sink (input valid, input char_valid, input char_code,
                input extended_key, input ctrl_action, output ready);
endinterface

/* sv/keyboard_scancode_to_ascii.sv */
// Set-1 keyboard scancode to ASCII converter, top level.
// Path: a scancode beat passes through the input register and the result register to the result beat.
// Throughput: one beat per cycle; the only limit is the result register draining.
// Reset (synchronous, rst high): both registers empty, shift/caps/ctrl/prefix clear,
// no pause skip pending.
// Depends on ksa_pkg and the channel interfaces in ksa_if.sv.
module keyboard_scancode_to_ascii
  import ksa_pkg::*;
#(
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  ksa_scan_if.sink   scan,
  ksa_char_if.source key
);

  localparam logic [7:0] MapLimit = 8'(MAP_ENTRIES);

  // Input register stage.
  logic       in_full;
  logic [7:0] in_code;

  // Result register stage.
  logic         out_full;
  logic         out_char_valid;
  logic [7:0]   out_char_code;
  logic         out_extended;
  ctrl_action_t out_action;

  // Keyboard state, advanced once per beat leaving the input register.
  logic       shift_held, shift_held_next;
  logic       caps_on, caps_on_next;
  logic       ctrl_held, ctrl_held_next;
  logic       after_prefix, after_prefix_next;
  logic [1:0] pause_skip, pause_skip_next;

  // Conversion results for the beat held in the input register.
  logic         conv_valid;
  logic [7:0]   conv_code;
  logic         conv_ext;
  ctrl_action_t conv_action;

  logic       advance;
  logic       is_release;
  logic [6:0] map_idx;

  // Move a beat forward when the result register is free or being drained.
  assign advance   = in_full && (!out_full || key.ready);
  assign scan.ready = !in_full || advance;

  assign is_release = (in_code & SC_RELEASE) != 8'h00;
  assign map_idx    = in_code[6:0];

  // Conversion uses the state as it stood before this beat.
  always_comb begin
    conv_valid  = 1'b0;
    conv_code   = 8'h00;
    conv_ext    = 1'b0;
    conv_action = ACT_NONE;
    if (pause_skip != 2'd0) begin
      // swallow: pause sequence bytes
    end else if (after_prefix) begin
      if (!is_release) begin
        conv_valid = 1'b1;
        conv_code  = in_code;
        conv_ext   = 1'b1;
      end
    end else if (in_code == SC_PREFIX_PAUSE || in_code == SC_PREFIX_EXT) begin
      // prefixes give nothing themselves
    end else if (!is_release) begin
      if (shift_held || caps_on || !ctrl_held) begin
        conv_valid = 1'b1;
        // Indexes at or past the table bound read as zero.
        if ({1'b0, map_idx} < MapLimit) begin
          conv_code = key_map({shift_held, caps_on}, map_idx);
        end
      end else if (in_code == SC_KEY_L) begin
        conv_action = ACT_CLEAR;
      end else if (in_code == SC_KEY_TAB) begin
        conv_action = ACT_SWITCH;
      end
    end
  end

  // State update applies to every byte, swallowed ones included.
  always_comb begin
    shift_held_next   = shift_held;
    caps_on_next      = caps_on;
    ctrl_held_next    = ctrl_held;
    pause_skip_next   = pause_skip;
    after_prefix_next = (in_code == SC_PREFIX_EXT);

    if (pause_skip != 2'd0) begin
      pause_skip_next = pause_skip - 2'd1;
    end else if (!after_prefix && in_code == SC_PREFIX_PAUSE) begin
      pause_skip_next = PAUSE_SKIP_LOAD;
    end

    if (is_release) begin
      if (in_code == SC_RSHIFT_UP || in_code == SC_LSHIFT_UP) begin
        shift_held_next = 1'b0;
      end
      if (in_code == SC_CTRL_UP) begin
        ctrl_held_next = 1'b0;
      end
    end else if (in_code == SC_CAPS) begin
      caps_on_next = !caps_on;
    end else if (in_code == SC_RSHIFT || in_code == SC_LSHIFT) begin
      shift_held_next = 1'b1;
    end else if (in_code == SC_CTRL) begin
      ctrl_held_next = 1'b1;
    end
  end

  // Control: occupancy of both stages and the keyboard state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      out_full     <= 1'b0;
      shift_held   <= 1'b0;
      caps_on      <= 1'b0;
      ctrl_held    <= 1'b0;
      after_prefix <= 1'b0;
      pause_skip   <= 2'd0;
    end else begin
      if (scan.ready) begin
        in_full <= scan.valid;
      end
      if (advance) begin
        out_full     <= 1'b1;
        shift_held   <= shift_held_next;
        caps_on      <= caps_on_next;
        ctrl_held    <= ctrl_held_next;
        after_prefix <= after_prefix_next;
        pause_skip   <= pause_skip_next;
      end else if (key.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // Payload: capture the scancode, hold results until taken.
  always_ff @(posedge clk) begin
    if (scan.ready && scan.valid) begin
      in_code <= scan.scancode;
    end
    if (advance) begin
      out_char_valid <= conv_valid;
      out_char_code  <= conv_code;
      out_extended   <= conv_ext;
      out_action     <= conv_action;
    end
  end

  assign key.valid        = out_full;
  assign key.char_valid   = out_char_valid;
  assign key.char_code    = out_char_code;
  assign key.extended_key = out_extended;
  assign key.ctrl_action  = out_action;

endmodule
